// ===== rtl/b64_pkg.sv =====
// Shared types, constants and the Base64 alphabet lookup for the encoder.
// Used by every module of the base64_encoder block; depends on nothing else.
package b64_pkg;

    localparam logic [6:0] CharPad   = 7'h3d;  // '='
    localparam logic [6:0] CharPlus  = 7'h2b;  // '+'
    localparam logic [6:0] CharSlash = 7'h2f;  // '/'
    localparam logic [6:0] CharDash  = 7'h2d;  // '-'
    localparam logic [6:0] CharUnder = 7'h5f;  // '_'
    localparam logic [6:0] CharUpA   = 7'h41;  // 'A'
    localparam logic [6:0] CharLowA  = 7'h61;  // 'a'
    localparam logic [6:0] CharZero  = 7'h30;  // '0'

    // One complete or closing group, handed from the front to the back.
    typedef struct packed {
        logic [23:0] triple;  // first byte in bits 23:16
        logic [1:0]  nbytes;  // valid bytes in the group, 1 to 3
        logic        last;    // group ends the message
        logic        url;     // URL-safe alphabet, no padding
    } grp_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Maps a 6-bit value to its Base64 character.
    function automatic logic [6:0] b64_sym(input logic [5:0] v, input logic url);
        logic [6:0] c;
        if (v < 6'd26) begin
            c = CharUpA + {1'b0, v};
        end else if (v < 6'd52) begin
            c = CharLowA + {1'b0, v - 6'd26};
        end else if (v < 6'd62) begin
            c = CharZero + {1'b0, v - 6'd52};
        end else if (v == 6'd62) begin
            c = url ? CharDash : CharPlus;
        end else begin
            c = url ? CharUnder : CharSlash;
        end
        return c;
    endfunction

endpackage

// ===== rtl/b64_front.sv =====
// Front end of the Base64 encoder: accepts bytes and gathers them into groups.
// Depends on b64_pkg for the group record type.
module b64_front
    import b64_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       url_safe,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_full,
    output logic       in_ready,
    output logic       push,
    output grp_t       rec
);

    logic [1:0]  fill_reg, fill_next;
    logic [15:0] held_reg, held_next;
    logic        accept;
    logic [1:0]  nbytes;
    logic [23:0] triple;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        case (fill_reg)
            2'd0: begin
                triple = {in_byte, 16'h0000};
                nbytes = 2'd1;
            end
            2'd1: begin
                triple = {held_reg[15:8], in_byte, 8'h00};
                nbytes = 2'd2;
            end
            default: begin
                triple = {held_reg, in_byte};
                nbytes = 2'd3;
            end
        endcase
    end

    // A group goes to the queue when it is full or the message ends.
    assign push       = accept && ((nbytes == 2'd3) || in_last);
    assign rec.triple = triple;
    assign rec.nbytes = nbytes;
    assign rec.last   = in_last;
    assign rec.url    = url_safe;

    always_comb begin
        fill_next = fill_reg;
        held_next = held_reg;
        if (accept) begin
            if (push) begin
                fill_next = 2'd0;
                held_next = 16'h0000;
            end else begin
                fill_next = nbytes;
                held_next = (fill_reg == 2'd0) ? {in_byte, 8'h00}
                                               : {held_reg[15:8], in_byte};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 2'd0;
            held_reg <= 16'h0000;
        end else begin
            fill_reg <= fill_next;
            held_reg <= held_next;
        end
    end

endmodule

// ===== rtl/b64_fifo.sv =====
// Short register queue of group records between the front and the back.
// Depends on b64_pkg for the record and status types.
module b64_fifo
    import b64_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  grp_t       wr_data,
    input  logic       pop,
    output grp_t       rd_data,
    output fifo_stat_t stat
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntMax = CntW'(DEPTH);

    grp_t          mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;

    assign rd_data    = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == CntMax);
    assign stat.empty = (cnt_reg == '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrMax) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrMax) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/b64_back.sv =====
// Back end of the Base64 encoder: turns queued groups into characters.
// Depends on b64_pkg for the record type, alphabet function and pad code.
module b64_back
    import b64_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  grp_t       head,
    input  logic       head_valid,
    output logic       pop,
    output logic       out_valid,
    output logic [6:0] out_char,
    output logic       out_last,
    input  logic       out_ready
);

    logic [1:0] k_reg, k_next;
    logic       valid_reg, valid_next;
    logic [6:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       load;
    logic       final_k;
    logic [6:0] sel_char;

    assign load    = head_valid && (!valid_reg || out_ready);
    // Without padding a group of n bytes gives n+1 characters, else four.
    assign final_k = (k_reg == (head.url ? head.nbytes : 2'd3));
    assign pop     = load && final_k;

    always_comb begin
        case (k_reg)
            2'd0: sel_char = b64_sym(head.triple[23:18], head.url);
            2'd1: sel_char = b64_sym(head.triple[17:12], head.url);
            2'd2: sel_char = (head.nbytes > 2'd1) ?
                             b64_sym(head.triple[11:6], head.url) : CharPad;
            default: sel_char = (head.nbytes > 2'd2) ?
                                b64_sym(head.triple[5:0], head.url) : CharPad;
        endcase
    end

    always_comb begin
        k_next     = k_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            char_next  = sel_char;
            last_next  = head.last && final_k;
            k_next     = final_k ? 2'd0 : k_reg + 2'd1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg     <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

// ===== rtl/base64_encoder.sv =====
// Streaming Base64 encoder top level. The closing byte of a group writes it into the
// queue, then the back end loads its first character into the output register.
// Throughput: one character per cycle while m_tready is high and the queue is not
// empty, so a long message gives four characters per three bytes; the queue of
// QUEUE_DEPTH groups absorbs bursts. Synchronous active-low reset empties the group
// and the queue, drops any pending character, and selects the standard alphabet.
module base64_encoder
    import b64_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration: url_safe register, written whenever cfg_we is high.
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    // Input byte stream.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    // Output character stream.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic       m_tlast    // last_char
);

    logic       url_safe_reg;
    logic       push;
    logic       pop;
    grp_t       rec;
    grp_t       head;
    fifo_stat_t q_stat;
    logic [6:0] out_char;

    // The mode must be changed only while the block is idle; the block does not enforce
    // it. Each group takes the value in force when its closing byte is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            url_safe_reg <= 1'b0;
        end else if (cfg_we) begin
            url_safe_reg <= cfg_wdata;
        end
    end

    // Front end gathers bytes into groups of up to three and queues each group
    // once it fills or the message ends.
    b64_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .url_safe (url_safe_reg),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_stat.full),
        .in_ready (s_tready),
        .push     (push),
        .rec      (rec)
    );

    // The queue decouples byte intake from character output.
    b64_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (rec),
        .pop     (pop),
        .rd_data (head),
        .stat    (q_stat)
    );

    // Back end walks the head group one character per cycle, while the output is
    // not stalled, into the output register.
    b64_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (!q_stat.empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_char   (out_char),
        .out_last   (m_tlast),
        .out_ready  (m_tready)
    );

    assign m_tdata = {1'b0, out_char};

    // The front must never write a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("group written into a full queue");

    // The back must never retire a group from an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("group retired from an empty queue");

    // Reset drops any pending output transaction.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
